### sv/assert_macros.svh
// Assertion macros used by the checker module of the bit set engine.
// No dependencies; included by the checker source file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is high
`define CHK_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, quiet while reset is high
`define CHK_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication that also holds across reset
`define CHK_NXT_ND(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

### sv/bse_pkg.sv
// Shared types and constants of the bit set engine.
// No dependencies; imported by bitmap_set_engine and bse_checker.
`timescale 1ns / 1ps

package bse_pkg;

   // item field widths
   localparam int FUNC_W     = 3;
   localparam int IDX_W      = 12;
   localparam int LEN_W      = 13;
   localparam int END_W      = 14;
   localparam int POS_W      = 13;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 16;

   // operation codes carried in req_tuser
   typedef enum logic [FUNC_W-1:0] {
      FN_TEST  = 3'd0,
      FN_SET   = 3'd1,
      FN_CLR   = 3'd2,
      FN_SETR  = 3'd3,
      FN_CLRR  = 3'd4,
      FN_COUNT = 3'd5,
      FN_FIND  = 3'd6,
      FN_NONE  = 3'd7
   } func_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIVA,
      ST_DIVB,
      ST_DIVC,
      ST_WALK,
      ST_ENC,
      ST_SUM,
      ST_DONE
   } state_type;

   // result item, flag in the lowest bit
   typedef struct packed {
      logic             err;
      logic [POS_W-1:0] pos;
      logic             flag;
   } res_type;

endpackage

### sv/bse_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies; holds the bit set words of the engine.
`timescale 1ns / 1ps

module bse_ram #(
   parameter int DATA_W = 64,
   parameter int DEPTH  = 64
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [DATA_W-1:0]                      wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [DATA_W-1:0]                      rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/bse_wdiv.sv
// Two-stage divider by a constant word size: quotient and remainder.
// No dependencies; splits bit positions into word and bit offset.
`timescale 1ns / 1ps

module bse_wdiv #(
   parameter int DIVISOR = 64,
   parameter int X_W     = 14
) (
   input  logic                                            clock,
   input  logic [X_W-1:0]                                  x,
   output logic [X_W-1:0]                                  q,
   output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] r
);

   localparam int R_W   = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
   localparam int RECIP = (1 << X_W) / DIVISOR;
   localparam int M_W   = $clog2(RECIP + 1);
   localparam int PR_W  = X_W + M_W;

   logic [X_W-1:0]  x_ff;
   logic [PR_W-1:0] prod_ff;
   logic [X_W-1:0]  q_est;
   logic [X_W-1:0]  rem_est;
   logic [X_W-1:0]  q_ff;
   logic [R_W-1:0]  r_ff;

   // stage 1: multiply by the truncated reciprocal
   always_ff @(posedge clock) begin
      x_ff    <= x;
      prod_ff <= PR_W'(x) * PR_W'(RECIP);
   end

   // estimate is exact or one low; one correction step fixes it
   assign q_est   = X_W'(prod_ff >> X_W);
   assign rem_est = x_ff - X_W'(q_est * X_W'(DIVISOR));

   // stage 2: correct and register
   always_ff @(posedge clock) begin
      if (rem_est >= X_W'(DIVISOR)) begin
         q_ff <= q_est + X_W'(1);
         r_ff <= R_W'(rem_est - X_W'(DIVISOR));
      end else begin
         q_ff <= q_est;
         r_ff <= R_W'(rem_est);
      end
   end

   assign q = q_ff;
   assign r = r_ff;

endmodule

### sv/bitmap_set_engine.sv
// Channel  | Dir | Payload
// req_     | in  | tuser: func; tdata: bit_index, range_length
// rsp_     | out | tdata: flag_bit, position_or_count, range_error
//
// Test, set and clear pass through DIVA, DIVB and WALK before the next acceptance.
// Set/clear range add DIVC and walk the words spanned; count walks the words in
// use, then sums; find next walks the words scanned, then encodes when a bit is
// found. Out-of-capacity items, a count with no words in use and the unused code
// finish in DIVA. One word a cycle passes through the single RAM port pair and
// the shared word-mask/popcount unit. After reset a clearing pass writes NUM_WORDS
// words, with no item accepted. A result held in the output register does not stop
// the next item from being accepted; a second result waits until it is taken.
// Depends on bse_pkg, bse_ram and bse_wdiv.
`timescale 1ns / 1ps

module bitmap_set_engine
   import bse_pkg::*;
#(
   parameter int NUM_WORDS = 64,
   parameter int WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [FUNC_W-1:0]     req_tuser,   // [2:0] func
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [11:0] bit_index, [24:12] range_length
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [0] flag_bit, [13:1] position_or_count,
                                              // [14] range_error
);

   localparam int CAP = NUM_WORDS * WORD_BITS;
   localparam int AW  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int UW  = $clog2(NUM_WORDS + 1);
   localparam int BW  = $clog2(WORD_BITS);
   localparam int PW  = $clog2(CAP);
   localparam int CW  = $clog2(CAP + 1);
   localparam int PCW = $clog2(WORD_BITS + 1);
   localparam int NCH = (WORD_BITS + 7) / 8;
   localparam logic [31:0] CAP32 = 32'(CAP);

   // set bits of one word, in byte chunks
   function automatic logic [PCW-1:0] popcnt(input logic [WORD_BITS-1:0] v);
      logic [NCH*8-1:0] pad;
      logic [3:0]       c;
      logic [PCW-1:0]   s;
      pad = (NCH*8)'(v);
      s   = '0;
      for (int k = 0; k < NCH; k++) begin
         c = '0;
         for (int j = 0; j < 8; j++) begin
            c = c + 4'(pad[k*8+j]);
         end
         s = s + PCW'(c);
      end
      return s;
   endfunction

   // position of the single set bit
   function automatic logic [BW-1:0] onehot_enc(input logic [WORD_BITS-1:0] v);
      logic [BW-1:0] e;
      e = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) begin
            e = e | BW'(i);
         end
      end
      return e;
   endfunction

   state_type            state_ff, state_in;
   func_type             func_ff, func_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [UW-1:0]        w_ff, w_in;
   logic [UW-1:0]        wlast_ff, wlast_in;
   logic [BW-1:0]        b0_ff, b0_in;
   logic [BW-1:0]        blast_ff, blast_in;
   logic                 first_ff, first_in;
   logic                 chg_ff, chg_in;
   logic [UW-1:0]        used_ff, used_in;
   logic [PCW-1:0]       pc_ff, pc_in;
   logic [CW-1:0]        acc_ff, acc_in;
   logic [PW-1:0]        base_ff, base_in;
   logic [WORD_BITS-1:0] iso_ff, iso_in;
   res_type              hold_ff, hold_in;
   res_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic                 fin;
   res_type              res;
   logic                 find_hit;
   logic                 cnt_last;
   logic                 out_free;
   logic                 load;
   logic                 op_err;
   logic [UW-1:0]        need;
   logic                 chg_now;

   logic [END_W-1:0]     end_w;
   logic [END_W-1:0]     div_x;
   logic [END_W-1:0]     div_q;
   logic [BW-1:0]        div_r;

   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [BW-1:0]        lo_sh, hi_sh;
   logic [WORD_BITS-1:0] mask_lo, mask_hi, rng_mask, bit_mask;
   logic [WORD_BITS-1:0] rng_word, fnd_word, fnd_iso;
   logic                 old_bit;
   logic                 last_w;
   logic [UW-1:0]        w_nx;

   // word store
   bse_ram #(
      .DATA_W (WORD_BITS),
      .DEPTH  (NUM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // position to word/bit split: start index at acceptance, range end next
   assign end_w = END_W'(idx_ff) + END_W'(len_ff);
   assign div_x = (state_ff == ST_IDLE) ? END_W'(req_tdata[IDX_W-1:0])
                                        : end_w - END_W'(1);

   bse_wdiv #(
      .DIVISOR (WORD_BITS),
      .X_W     (END_W)
   ) u_wdiv (
      .clock (clock),
      .x     (div_x),
      .q     (div_q),
      .r     (div_r)
   );

   // word masks for the current word
   assign lo_sh    = first_ff ? b0_ff : '0;
   assign last_w   = (w_ff == wlast_ff);
   assign hi_sh    = last_w ? blast_ff : BW'(WORD_BITS - 1);
   assign mask_lo  = {WORD_BITS{1'b1}} << lo_sh;
   assign mask_hi  = {WORD_BITS{1'b1}} >> (BW'(WORD_BITS - 1) - hi_sh);
   assign rng_mask = mask_lo & mask_hi;
   assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << b0_ff;
   assign rng_word = (func_ff == FN_SETR) ? (rd_data | rng_mask) : (rd_data & ~rng_mask);
   assign chg_now  = chg_ff | (rng_word != rd_data);
   assign fnd_word = rd_data & mask_lo;
   assign fnd_iso  = fnd_word & (~fnd_word + WORD_BITS'(1));
   assign old_bit  = |(rd_data & bit_mask);
   assign w_nx     = w_ff + UW'(1);

   // capacity checks
   always_comb begin
      case (func_ff)
         FN_TEST, FN_SET, FN_CLR, FN_FIND: op_err = (32'(idx_ff) >= CAP32);
         FN_SETR, FN_CLRR:                 op_err = (32'(end_w) > CAP32);
         default:                          op_err = 1'b0;
      endcase
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   // datapath and sequencer outputs
   always_comb begin
      func_in   = func_ff;
      idx_in    = idx_ff;
      len_in    = len_ff;
      w_in      = w_ff;
      wlast_in  = wlast_ff;
      b0_in     = b0_ff;
      blast_in  = blast_ff;
      first_in  = first_ff;
      chg_in    = chg_ff;
      used_in   = used_ff;
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      base_in   = base_ff;
      iso_in    = iso_ff;
      rd_en     = 1'b0;
      rd_addr   = w_ff[AW-1:0];
      wr_en     = 1'b0;
      wr_addr   = w_ff[AW-1:0];
      wr_data   = '0;
      fin       = 1'b0;
      res       = '0;
      find_hit  = 1'b0;
      cnt_last  = 1'b0;
      need      = '0;

      case (state_ff)
         ST_INIT: begin
            wr_en = 1'b1;
            w_in  = w_nx;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in = func_type'(req_tuser);
               idx_in  = req_tdata[IDX_W-1:0];
               len_in  = req_tdata[IDX_W+LEN_W-1:IDX_W];
            end
         end
         ST_DIVA: begin
            if (op_err) begin
               fin     = 1'b1;
               res.err = 1'b1;
            end else if (func_ff == FN_NONE) begin
               fin = 1'b1;
            end else if (func_ff == FN_COUNT) begin
               if (used_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = '0;
                  w_in    = '0;
                  acc_in  = '0;
                  pc_in   = '0;
               end
            end
         end
         ST_DIVB: begin
            // start word and bit offset
            w_in     = div_q[UW-1:0];
            b0_in    = div_r;
            first_in = 1'b1;
            base_in  = PW'(idx_ff) - PW'(div_r);
            case (func_ff)
               FN_TEST, FN_CLR: begin
                  rd_en   = 1'b1;
                  rd_addr = div_q[AW-1:0];
               end
               FN_SET: begin
                  rd_en   = 1'b1;
                  rd_addr = div_q[AW-1:0];
                  need    = div_q[UW-1:0] + UW'(1);
                  if (need > used_ff) begin
                     used_in = need;
                  end
               end
               FN_FIND: begin
                  if (div_q >= END_W'(used_ff)) begin
                     fin = 1'b1;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = div_q[AW-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         ST_DIVC: begin
            // last word of the range; grow to cover the range end
            wlast_in = div_q[UW-1:0];
            blast_in = div_r;
            if (end_w != '0) begin
               need = div_q[UW-1:0] + UW'(1);
               if (need > used_ff) begin
                  used_in = need;
               end
            end
            if (len_ff == '0) begin
               fin = 1'b1;
            end else begin
               rd_en    = 1'b1;
               first_in = 1'b1;
               chg_in   = 1'b0;
            end
         end
         ST_WALK: begin
            case (func_ff)
               FN_TEST: begin
                  fin      = 1'b1;
                  res.flag = old_bit;
               end
               FN_SET: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data | bit_mask;
                  fin      = 1'b1;
                  res.flag = !old_bit;
               end
               FN_CLR: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data & ~bit_mask;
                  fin      = 1'b1;
                  res.flag = old_bit;
               end
               FN_SETR, FN_CLRR: begin
                  wr_en   = 1'b1;
                  wr_data = rng_word;
                  chg_in  = chg_now;
                  if (last_w) begin
                     fin      = 1'b1;
                     res.flag = chg_now;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = w_nx[AW-1:0];
                     w_in     = w_nx;
                     first_in = 1'b0;
                  end
               end
               FN_COUNT: begin
                  pc_in  = popcnt(rd_data);
                  acc_in = acc_ff + CW'(pc_ff);
                  if (w_nx == used_ff) begin
                     cnt_last = 1'b1;
                  end else begin
                     rd_en   = 1'b1;
                     rd_addr = w_nx[AW-1:0];
                     w_in    = w_nx;
                  end
               end
               FN_FIND: begin
                  if (|fnd_word) begin
                     find_hit = 1'b1;
                     iso_in   = fnd_iso;
                  end else if (w_nx < used_ff) begin
                     rd_en    = 1'b1;
                     rd_addr  = w_nx[AW-1:0];
                     w_in     = w_nx;
                     first_in = 1'b0;
                     base_in  = base_ff + PW'(WORD_BITS);
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_ENC: begin
            fin      = 1'b1;
            res.flag = 1'b1;
            res.pos  = POS_W'(base_ff + PW'(onehot_enc(iso_ff)));
         end
         ST_SUM: begin
            fin     = 1'b1;
            res.pos = POS_W'(acc_ff + CW'(pc_ff));
         end
         default: begin
         end
      endcase

      // output register, with a holding slot while it is occupied
      hold_in      = fin ? res : hold_ff;
      load         = out_free && (fin || (state_ff == ST_DONE));
      rsp_in       = load ? ((state_ff == ST_DONE) ? hold_ff : res) : rsp_ff;
      rsp_valid_in = load || (rsp_valid_ff && !rsp_tready);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (fin) begin
         state_in = out_free ? ST_IDLE : ST_DONE;
      end else begin
         case (state_ff)
            ST_INIT: begin
               if (w_ff == UW'(NUM_WORDS - 1)) begin
                  state_in = ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_in = ST_DIVA;
               end
            end
            ST_DIVA: begin
               state_in = (func_ff == FN_COUNT) ? ST_WALK : ST_DIVB;
            end
            ST_DIVB: begin
               if (func_ff == FN_SETR || func_ff == FN_CLRR) begin
                  state_in = ST_DIVC;
               end else begin
                  state_in = ST_WALK;
               end
            end
            ST_DIVC: state_in = ST_WALK;
            ST_WALK: begin
               if (find_hit) begin
                  state_in = ST_ENC;
               end else if (cnt_last) begin
                  state_in = ST_SUM;
               end
            end
            ST_DONE: begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         w_ff         <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         w_ff         <= w_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      wlast_ff <= wlast_in;
      b0_ff    <= b0_in;
      blast_ff <= blast_in;
      first_ff <= first_in;
      chg_ff   <= chg_in;
      pc_ff    <= pc_in;
      acc_ff   <= acc_in;
      base_ff  <= base_in;
      iso_ff   <= iso_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

### sv/bse_checker.sv
// Port-level checks on the bit set engine, bound to its top level.
// Depends on bse_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bse_checker
   import bse_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [FUNC_W-1:0]     req_tuser,
   input logic [REQ_DATA_W-1:0] req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic req_acc;

   assign req_acc = req_tvalid && req_tready;

   // an accepted item keeps the engine busy for at least the next cycle
   `CHK_NXT(a_busy_after_accept, clock, reset, req_acc, !req_tready)

   // a stalled result stays put
   `CHK_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // an out-of-capacity result carries no flag and no position
   `CHK_IMP(a_err_clean, clock, reset, rsp_tvalid && rsp_tdata[14], rsp_tdata[13:0] == 14'h0)

   // reset empties the output and starts the clearing pass
   `CHK_NXT_ND(a_reset_quiet, clock, reset, !rsp_tvalid && !req_tready)

endmodule

bind bitmap_set_engine bse_checker u_bse_checker (.*);
